@@ src/sobel_edge_magnitude_rgb_core_defines.svh @@
// assertion macros shared by the sobel edge magnitude checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sem_pkg.sv @@
// shared types and constants of the sobel edge magnitude core
// no dependencies
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int CW_W        = 11;
    localparam int CH_W        = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int EMIT_W      = 22;
    localparam int DIV_STEPS   = EMIT_W;
    localparam int ROOT_STEPS  = 11;
    localparam int STEP_W      = 5;

    localparam logic [CW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CH_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic CFG_WIDTH_IDX  = 1'b0;
    localparam logic CFG_HEIGHT_IDX = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ src/sobel_edge_magnitude_rgb_core.sv @@
// Flow: an accepted pixel word is read from the line store; a word that emits nothing then
// returns to idle, and an emitting word passes the 22-step position divider, the gradient,
// square and sum steps and the 11-step root, and waits while the result side stalls. One
// word is in flight at a time, so a new word is not taken before the last one is through.
// Reset: async active low; line stores are swept to zero after reset, during which
// pix_stall stays high. Width/height reset to 640/480.
// depends on sem_pkg
`default_nettype none

module sobel_edge_magnitude_rgb_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire logic                              mode,
    input  wire logic [7:0]                        red_in,
    input  wire logic [7:0]                        green_in,
    input  wire logic [7:0]                        blue_in,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [7:0]                             red_out,
    output logic [7:0]                             green_out,
    output logic [7:0]                             blue_out,
    output logic                                   frame_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = sem_pkg::ADDR_W;

    sem_pkg::state_t state_reg, state_next;

    logic [sem_pkg::CW_W-1:0]   width_reg;
    logic [sem_pkg::CH_W-1:0]   height_reg;
    logic [sem_pkg::CW_W-1:0]   w_eff;
    logic [sem_pkg::CH_W-1:0]   h_eff;
    logic [22:0]                area;

    logic [AW-1:0]              col_reg;
    logic [11:0]                row_reg;
    logic [sem_pkg::EMIT_W-1:0] emit_cnt_reg;
    logic [23:0]                win_reg [0:5];

    logic [47:0]                line_mem [0:sem_pkg::MAX_WIDTH-1];
    logic [47:0]                mem_q_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [47:0]                mem_wdata;

    logic [23:0]                bottom_reg;
    logic [23:0]                pix_reg [0:8];
    logic                       last_reg;
    logic [sem_pkg::STEP_W-1:0] step_reg;

    logic [sem_pkg::EMIT_W-1:0] div_num_reg;
    logic [sem_pkg::EMIT_W-1:0] quo_reg;
    logic [sem_pkg::CW_W-1:0]   rem_reg;

    logic signed [10:0]         gx_reg [0:2];
    logic signed [10:0]         gy_reg [0:2];
    logic [19:0]                sqx_reg [0:2];
    logic [19:0]                sqy_reg [0:2];
    logic [21:0]                rad_reg [0:2];
    logic [10:0]                root_reg [0:2];
    logic [11:0]                rrem_reg [0:2];

    logic                       res_valid_reg;
    logic [7:0]                 red_reg, green_reg, blue_reg;
    logic                       last_out_reg;

    logic                       emit;
    logic                       is_last;
    logic                       res_load;
    logic [23:0]                top_px, mid_px;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 11'd1;
        else if (width_reg > 11'(sem_pkg::MAX_WIDTH))
            w_eff = 11'(sem_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? 12'd1 : height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sem_pkg::CFG_WIDTH_IDX:  width_reg  <= cfg_data[sem_pkg::CW_W-1:0];
                sem_pkg::CFG_HEIGHT_IDX: height_reg <= cfg_data[sem_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // frame area from the current size registers
    assign area = {12'd0, w_eff} * {11'd0, h_eff};

    assign top_px = mem_q_reg[47:24];
    assign mid_px = mem_q_reg[23:0];

    always_comb
    begin
        emit = (row_reg >= 12'd2) || (row_reg == 12'd1 && col_reg != '0) ||
               (row_reg == 12'd0 && {2'b00, col_reg} >= ({1'b0, w_eff} + 12'd1));
        is_last = emit && (({1'b0, emit_cnt_reg} + 23'd1) >= area);
        res_load = (state_reg == sem_pkg::ST_DONE) && (!res_valid_reg || !res_stall);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::ST_CLEAR:  if (clr_addr_reg == {AW{1'b1}}) state_next = sem_pkg::ST_IDLE;
            sem_pkg::ST_IDLE:   if (pix_valid) state_next = sem_pkg::ST_READ;
            sem_pkg::ST_READ:   state_next = emit ? sem_pkg::ST_DIV : sem_pkg::ST_IDLE;
            sem_pkg::ST_DIV:
                if (step_reg == 5'(sem_pkg::DIV_STEPS - 1)) state_next = sem_pkg::ST_GRAD;
            sem_pkg::ST_GRAD:   state_next = sem_pkg::ST_SQUARE;
            sem_pkg::ST_SQUARE: state_next = sem_pkg::ST_SUM;
            sem_pkg::ST_SUM:    state_next = sem_pkg::ST_ROOT;
            sem_pkg::ST_ROOT:
                if (step_reg == 5'(sem_pkg::ROOT_STEPS - 1)) state_next = sem_pkg::ST_DONE;
            sem_pkg::ST_DONE:   if (res_load) state_next = sem_pkg::ST_IDLE;
            default:            state_next = sem_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pix_stall = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = col_reg;
        mem_wdata = {mid_px, bottom_reg};
        unique case (state_reg)
            sem_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            sem_pkg::ST_IDLE: pix_stall = 1'b0;
            sem_pkg::ST_READ: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sem_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // line store: upper row in the high half, middle row in the low half
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= mem_wdata;
        mem_q_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            emit_cnt_reg <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == sem_pkg::ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (state_reg == sem_pkg::ST_READ)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_px;
                win_reg[4] <= mid_px;
                win_reg[5] <= bottom_reg;
                if (is_last)
                begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    emit_cnt_reg <= '0;
                end
                else
                begin
                    if (emit)
                        emit_cnt_reg <= emit_cnt_reg + 1'b1;
                    if (({1'b0, col_reg} + 11'd1) >= w_eff)
                    begin
                        col_reg <= '0;
                        if (row_reg != 12'd4095)
                            row_reg <= row_reg + 1'b1;
                    end
                    else
                        col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        logic [11:0]  trial;
        logic [13:0]  rtrial;
        logic [13:0]  rcand;
        logic         r0_out, r2_out, c0_out, c2_out;
        logic [23:0]  m [0:8];
        logic [7:0]   p [0:8];
        logic [9:0]   s_a, s_b, s_c, s_d;
        logic signed [21:0] prod_x, prod_y;

        unique case (state_reg)
            sem_pkg::ST_IDLE:
                bottom_reg <= mode ? 24'd0 : {red_in, green_in, blue_in};
            sem_pkg::ST_READ:
            begin
                pix_reg[0] <= win_reg[0]; pix_reg[3] <= win_reg[1]; pix_reg[6] <= win_reg[2];
                pix_reg[1] <= win_reg[3]; pix_reg[4] <= win_reg[4]; pix_reg[7] <= win_reg[5];
                pix_reg[2] <= top_px;     pix_reg[5] <= mid_px;     pix_reg[8] <= bottom_reg;
                last_reg    <= is_last;
                div_num_reg <= emit_cnt_reg;
                rem_reg     <= '0;
                step_reg    <= '0;
            end
            sem_pkg::ST_DIV:
            begin
                // restoring divide of the output index by the width
                trial = {rem_reg, div_num_reg[sem_pkg::EMIT_W-1]};
                if (trial >= {1'b0, w_eff})
                begin
                    rem_reg <= 11'(trial - {1'b0, w_eff});
                    quo_reg <= {quo_reg[sem_pkg::EMIT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[10:0];
                    quo_reg <= {quo_reg[sem_pkg::EMIT_W-2:0], 1'b0};
                end
                div_num_reg <= {div_num_reg[sem_pkg::EMIT_W-2:0], 1'b0};
                step_reg    <= step_reg + 1'b1;
            end
            sem_pkg::ST_GRAD:
            begin
                r0_out = (quo_reg == '0);
                r2_out = (({1'b0, quo_reg} + 23'd1) >= {11'd0, h_eff});
                c0_out = (rem_reg == '0);
                c2_out = (({1'b0, rem_reg} + 12'd1) >= {1'b0, w_eff});
                for (int i = 0; i < 9; i++)
                begin
                    if ((i < 3 && r0_out) || (i >= 6 && r2_out) ||
                        (i % 3 == 0 && c0_out) || (i % 3 == 2 && c2_out))
                        m[i] = '0;
                    else
                        m[i] = pix_reg[i];
                end
                for (int k = 0; k < 3; k++)
                begin
                    for (int i = 0; i < 9; i++)
                        p[i] = m[i][23 - 8*k -: 8];
                    s_a = {2'b00, p[2]} + {1'b0, p[5], 1'b0} + {2'b00, p[8]};
                    s_b = {2'b00, p[0]} + {1'b0, p[3], 1'b0} + {2'b00, p[6]};
                    s_c = {2'b00, p[6]} + {1'b0, p[7], 1'b0} + {2'b00, p[8]};
                    s_d = {2'b00, p[0]} + {1'b0, p[1], 1'b0} + {2'b00, p[2]};
                    gx_reg[k] <= $signed({1'b0, s_a}) - $signed({1'b0, s_b});
                    gy_reg[k] <= $signed({1'b0, s_c}) - $signed({1'b0, s_d});
                end
            end
            sem_pkg::ST_SQUARE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_x = 22'(gx_reg[k]) * 22'(gx_reg[k]);
                    prod_y = 22'(gy_reg[k]) * 22'(gy_reg[k]);
                    sqx_reg[k] <= prod_x[19:0];
                    sqy_reg[k] <= prod_y[19:0];
                end
            end
            sem_pkg::ST_SUM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rad_reg[k]  <= {2'b00, sqx_reg[k]} + {2'b00, sqy_reg[k]};
                    root_reg[k] <= '0;
                    rrem_reg[k] <= '0;
                end
                step_reg <= '0;
            end
            sem_pkg::ST_ROOT:
            begin
                // two radicand bits per step, remainder kept for rounding
                for (int k = 0; k < 3; k++)
                begin
                    rcand  = {rrem_reg[k], rad_reg[k][21:20]};
                    rtrial = {1'b0, root_reg[k], 2'b01};
                    if (rcand >= rtrial)
                    begin
                        rrem_reg[k] <= 12'(rcand - rtrial);
                        root_reg[k] <= {root_reg[k][9:0], 1'b1};
                    end
                    else
                    begin
                        rrem_reg[k] <= rcand[11:0];
                        root_reg[k] <= {root_reg[k][9:0], 1'b0};
                    end
                    rad_reg[k] <= {rad_reg[k][19:0], 2'b00};
                end
                step_reg <= step_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // round half up and cap at 255
    function automatic logic [7:0] round_cap(input logic [10:0] q, input logic [11:0] r);
        logic [11:0] qr;
        qr = {1'b0, q} + ((r > {1'b0, q}) ? 12'd1 : 12'd0);
        return (qr > 12'd255) ? 8'd255 : qr[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            red_reg      <= round_cap(root_reg[0], rrem_reg[0]);
            green_reg    <= round_cap(root_reg[1], rrem_reg[1]);
            blue_reg     <= round_cap(root_reg[2], rrem_reg[2]);
            last_out_reg <= last_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign frame_last = last_out_reg;

endmodule

`default_nettype wire

@@ src/sem_checker.sv @@
// port-level checks for the sobel edge magnitude core, bound to the top level
// depends on sobel_edge_magnitude_rgb_core_defines.svh
`default_nettype none
`include "sobel_edge_magnitude_rgb_core_defines.svh"

module sem_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           pix_valid,
    input wire logic                           pix_stall,
    input wire logic                           res_valid,
    input wire logic                           res_stall,
    input wire logic [7:0]                     red_out,
    input wire logic [7:0]                     green_out,
    input wire logic [7:0]                     blue_out,
    input wire logic                           frame_last,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready
);

    // one word at a time: an accepted word closes the input on the next cycle
    `SEM_ASSERT_NEXT(a_one_in_flight, pix_valid && !pix_stall, pix_stall, "input open after accept")

    // line store sweep holds the input after reset release
    `SEM_ASSERT_NOW(a_clear_stall, $rose(rst_n), pix_stall, "input open during store clear")

    `SEM_ASSERT_NOW(a_cfg_ready, cfg_valid || !cfg_valid, cfg_ready, "config port not ready")

    `SEM_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out)
        && $stable(frame_last), "stalled result changed")

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (.*);

`default_nettype wire
